/* hw/rtl/line_box_boundary_points_top_assert.svh */
// Assertion macros for the line box boundary points block and its checker.
`ifndef LINE_BOX_BOUNDARY_POINTS_TOP_ASSERT_SVH
`define LINE_BOX_BOUNDARY_POINTS_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted
`define LBBP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted
`define LBBP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/lbbp_pkg.sv */
// Shared constants and types for the line box boundary points block.
`timescale 1ns / 1ps
package lbbp_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int NUM_LANES       = 4;
	localparam int CFG_IDX_W       = 2;

	// second corner resets to 1.0 in the default format
	localparam logic [63:0] CORNER_B_RST = 64'd65536;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_ZERO_DIR = 2'd1;
	localparam status_t ST_SPLIT    = 2'd2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_A_X = 2'd0;
	localparam cfg_idx_t REG_A_Y = 2'd1;
	localparam cfg_idx_t REG_B_X = 2'd2;
	localparam cfg_idx_t REG_B_Y = 2'd3;

endpackage

/* hw/rtl/lbbp_query_if.sv */
// Query channel: point and direction item with valid/ready.
`timescale 1ns / 1ps
interface lbbp_query_if #(
	parameter int COORD_WIDTH = lbbp_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic signed [COORD_WIDTH-1:0] dir_x;
	logic signed [COORD_WIDTH-1:0] dir_y;

	modport source (output valid, output point_x, output point_y, output dir_x,
		output dir_y, input ready);
	modport sink (input valid, input point_x, input point_y, input dir_x,
		input dir_y, output ready);
endinterface

/* hw/rtl/lbbp_result_if.sv */
// Result channel: boundary points and status item with valid/ready.
`timescale 1ns / 1ps
interface lbbp_result_if #(
	parameter int COORD_WIDTH = lbbp_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] back_x;
	logic signed [COORD_WIDTH-1:0] back_y;
	logic signed [COORD_WIDTH-1:0] fwd_x;
	logic signed [COORD_WIDTH-1:0] fwd_y;
	lbbp_pkg::status_t             status;

	modport source (output valid, output back_x, output back_y, output fwd_x,
		output fwd_y, output status, input ready);
	modport sink (input valid, input back_x, input back_y, input fwd_x,
		input fwd_y, input status, output ready);
endinterface

/* hw/rtl/line_box_boundary_points_top.sv */
// Items pass stage 1, the four restoring dividers of stage 2, then stages 3 to 6, in order.
// Throughput: one item per cycle unless the result stalls; one quotient bit per divider stage.
// Pipeline bubbles collapse, so a stalled result still lets upstream stages fill.
// Reset (arst_n low, asynchronous): all valid bits clear, corner A = 0, corner B = 1.0.
`timescale 1ns / 1ps
module line_box_boundary_points_top #(
	parameter int COORD_WIDTH = lbbp_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = lbbp_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lbbp_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [COORD_WIDTH-1:0]         cfg_wdata,
	lbbp_query_if.sink                     query,
	lbbp_result_if.source                  result
);

	localparam int W  = COORD_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int QW = W + 1 + F;
	localparam int PW = 2 * W;
	localparam int NL = lbbp_pkg::NUM_LANES;

	typedef struct packed {
		logic signed [W-1:0] px;
		logic signed [W-1:0] py;
		logic signed [W-1:0] dx;
		logic signed [W-1:0] dy;
		logic [W-1:0]        adx;
		logic [W-1:0]        ady;
		logic [NL-1:0]       neg;
		logic                zero;
	} side_t;

	// configuration registers
	logic signed [W-1:0] a_x_q, a_y_q, b_x_q, b_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_x_q <= '0;
			a_y_q <= '0;
			b_x_q <= lbbp_pkg::CORNER_B_RST[W-1:0];
			b_y_q <= lbbp_pkg::CORNER_B_RST[W-1:0];
		end else if (cfg_we) begin
			case (cfg_idx)
				lbbp_pkg::REG_A_X: a_x_q <= cfg_wdata;
				lbbp_pkg::REG_A_Y: a_y_q <= cfg_wdata;
				lbbp_pkg::REG_B_X: b_x_q <= cfg_wdata;
				lbbp_pkg::REG_B_Y: b_y_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// pipeline state
	logic              v_s1, v_s3, v_s4, v_s5, v_s6;
	logic              v_s2 [QW];
	logic              en_s1, en_s3, en_s4, en_s5, en_s6;
	logic              en_s2 [QW];

	side_t             side_s1;
	logic [QW-1:0]     num_s1 [NL];
	side_t             side_s2 [QW];
	logic [QW-1:0]     num_s2 [QW][NL];
	logic [W-1:0]      rem_s2 [QW][NL];
	logic [QW-1:0]     quo_s2 [QW][NL];
	side_t             side_s3;
	logic signed [W-1:0] t_s3 [NL];
	logic signed [W-1:0] px_s4, py_s4, dx_s4, dy_s4, tn_s4, tp_s4;
	lbbp_pkg::status_t st_s4, st_s5, st_s6;
	logic signed [W-1:0] px_s5, py_s5;
	logic signed [PW-1:0] prod_s5 [NL];
	logic signed [W-1:0] pt_s6 [NL];

	// stall chain: a stage moves when it is empty or the next one moves
	always_comb begin
		en_s6 = !v_s6 || result.ready;
		en_s5 = !v_s5 || en_s6;
		en_s4 = !v_s4 || en_s5;
		en_s3 = !v_s3 || en_s4;
		en_s2[QW-1] = !v_s2[QW-1] || en_s3;
		for (int k = QW - 2; k >= 0; k--) begin
			en_s2[k] = !v_s2[k] || en_s2[k+1];
		end
		en_s1 = !v_s1 || en_s2[0];
	end

	assign query.ready = en_s1;

	// stage 1: corner differences, signs, magnitudes
	logic signed [W-1:0] cor [NL];
	logic signed [W:0]   diff [NL];
	side_t               side_n1;
	logic [QW-1:0]       num_n1 [NL];

	always_comb begin
		cor[0] = a_x_q;
		cor[1] = a_y_q;
		cor[2] = b_x_q;
		cor[3] = b_y_q;
		side_n1.px   = query.point_x;
		side_n1.py   = query.point_y;
		side_n1.dx   = query.dir_x;
		side_n1.dy   = query.dir_y;
		side_n1.adx  = query.dir_x[W-1] ? W'(-query.dir_x) : query.dir_x;
		side_n1.ady  = query.dir_y[W-1] ? W'(-query.dir_y) : query.dir_y;
		side_n1.zero = (query.dir_x == '0) || (query.dir_y == '0);
		for (int l = 0; l < NL; l++) begin
			if ((l & 1) == 0) begin
				diff[l] = (W+1)'(cor[l]) - (W+1)'(query.point_x);
				side_n1.neg[l] = (diff[l] != '0) && (diff[l][W] != query.dir_x[W-1]);
			end else begin
				diff[l] = (W+1)'(cor[l]) - (W+1)'(query.point_y);
				side_n1.neg[l] = (diff[l] != '0) && (diff[l][W] != query.dir_y[W-1]);
			end
			num_n1[l] = {(diff[l][W] ? (W+1)'(-diff[l]) : diff[l]), {F{1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en_s1) v_s1 <= query.valid;
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			side_s1 <= side_n1;
			num_s1  <= num_n1;
		end
	end

	// stage 2: restoring dividers, one quotient bit per stage per lane
	side_t         side_n2 [QW];
	logic [QW-1:0] num_n2 [QW][NL];
	logic [W-1:0]  rem_n2 [QW][NL];
	logic [QW-1:0] quo_n2 [QW][NL];
	logic [QW-1:0] pn, pq;
	logic [W-1:0]  pr, den;
	logic [W:0]    trial;
	side_t         ps;

	always_comb begin
		for (int k = 0; k < QW; k++) begin
			side_n2[k] = (k == 0) ? side_s1 : side_s2[k-1];
			for (int l = 0; l < NL; l++) begin
				if (k == 0) begin
					pn = num_s1[l];
					pr = '0;
					pq = '0;
					ps = side_s1;
				end else begin
					pn = num_s2[k-1][l];
					pr = rem_s2[k-1][l];
					pq = quo_s2[k-1][l];
					ps = side_s2[k-1];
				end
				den = ((l & 1) == 0) ? ps.adx : ps.ady;
				trial = {pr, pn[QW-1]};
				num_n2[k][l] = pn << 1;
				if (trial >= {1'b0, den}) begin
					rem_n2[k][l] = W'(trial - {1'b0, den});
					quo_n2[k][l] = {pq[QW-2:0], 1'b1};
				end else begin
					rem_n2[k][l] = trial[W-1:0];
					quo_n2[k][l] = {pq[QW-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QW; k++) v_s2[k] <= 1'b0;
		end else begin
			for (int k = 0; k < QW; k++) begin
				if (en_s2[k]) v_s2[k] <= (k == 0) ? v_s1 : v_s2[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < QW; k++) begin
			if (en_s2[k]) begin
				side_s2[k] <= side_n2[k];
				num_s2[k]  <= num_n2[k];
				rem_s2[k]  <= rem_n2[k];
				quo_s2[k]  <= quo_n2[k];
			end
		end
	end

	// stage 3: apply sign and saturate the slab parameters
	localparam logic [QW-1:0] Q_MAXP = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic [QW-1:0] Q_MAGN = Q_MAXP + QW'(1);
	logic signed [W-1:0] t_n3 [NL];

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			if (side_s2[QW-1].neg[l]) begin
				if (quo_s2[QW-1][l] > Q_MAGN) t_n3[l] = {1'b1, {(W-1){1'b0}}};
				else t_n3[l] = -quo_s2[QW-1][l][W-1:0];
			end else begin
				if (quo_s2[QW-1][l] > Q_MAXP) t_n3[l] = {1'b0, {(W-1){1'b1}}};
				else t_n3[l] = quo_s2[QW-1][l][W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en_s3) v_s3 <= v_s2[QW-1];
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			side_s3 <= side_s2[QW-1];
			t_s3    <= t_n3;
		end
	end

	// stage 4: nearest parameter in each sign group, first one on a tie
	logic [2:0]          cnt_n, cnt_p;
	logic signed [W-1:0] best_n, best_p;
	logic [W:0]          mag_t, mag_n, mag_p;
	lbbp_pkg::status_t   st_n4;

	always_comb begin
		cnt_n  = '0;
		cnt_p  = '0;
		best_n = '0;
		best_p = '0;
		for (int l = 0; l < NL; l++) begin
			mag_t = t_s3[l][W-1] ? -(W+1)'(t_s3[l]) : (W+1)'(t_s3[l]);
			mag_n = best_n[W-1] ? -(W+1)'(best_n) : (W+1)'(best_n);
			mag_p = best_p[W-1] ? -(W+1)'(best_p) : (W+1)'(best_p);
			if (side_s3.neg[l]) begin
				if (cnt_n == '0 || mag_t < mag_n) best_n = t_s3[l];
				cnt_n = cnt_n + 3'd1;
			end else begin
				if (cnt_p == '0 || mag_t < mag_p) best_p = t_s3[l];
				cnt_p = cnt_p + 3'd1;
			end
		end
		if (side_s3.zero) st_n4 = lbbp_pkg::ST_ZERO_DIR;
		else if (cnt_n != 3'd2) st_n4 = lbbp_pkg::ST_SPLIT;
		else st_n4 = lbbp_pkg::ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en_s4) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			px_s4 <= side_s3.px;
			py_s4 <= side_s3.py;
			dx_s4 <= side_s3.dx;
			dy_s4 <= side_s3.dy;
			tn_s4 <= best_n;
			tp_s4 <= best_p;
			st_s4 <= st_n4;
		end
	end

	// stage 5: offsets along the direction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en_s5) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			prod_s5[0] <= PW'(dx_s4) * PW'(tn_s4);
			prod_s5[1] <= PW'(dy_s4) * PW'(tn_s4);
			prod_s5[2] <= PW'(dx_s4) * PW'(tp_s4);
			prod_s5[3] <= PW'(dy_s4) * PW'(tp_s4);
			px_s5      <= px_s4;
			py_s5      <= py_s4;
			st_s5      <= st_s4;
		end
	end

	// stage 6: floor shift, add start point, saturate, zero on bad status
	logic signed [PW-1:0] ofs [NL];
	logic signed [PW:0]   sum [NL];
	logic signed [W-1:0]  pt_n6 [NL];

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			ofs[l] = prod_s5[l] >>> F;
			if ((l & 1) == 0) sum[l] = (PW+1)'(px_s5) + (PW+1)'(ofs[l]);
			else sum[l] = (PW+1)'(py_s5) + (PW+1)'(ofs[l]);
			if (st_s5 != lbbp_pkg::ST_OK) begin
				pt_n6[l] = '0;
			end else if (sum[l][PW:W-1] == '0 || sum[l][PW:W-1] == '1) begin
				pt_n6[l] = sum[l][W-1:0];
			end else begin
				pt_n6[l] = {sum[l][PW], {(W-1){!sum[l][PW]}}};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en_s6) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			pt_s6 <= pt_n6;
			st_s6 <= st_s5;
		end
	end

	assign result.valid  = v_s6;
	assign result.back_x = pt_s6[0];
	assign result.back_y = pt_s6[1];
	assign result.fwd_x  = pt_s6[2];
	assign result.fwd_y  = pt_s6[3];
	assign result.status = st_s6;

endmodule

/* hw/rtl/lbbp_chk.sv */
// Port-level checker for the line box boundary points block, with its bind.
`timescale 1ns / 1ps
`include "line_box_boundary_points_top_assert.svh"
module lbbp_chk #(
	parameter int COORD_WIDTH = lbbp_pkg::COORD_WIDTH_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   q_valid,
	input logic                   q_ready,
	input logic                   r_valid,
	input logic                   r_ready,
	input logic [COORD_WIDTH-1:0] r_back_x,
	input logic [COORD_WIDTH-1:0] r_back_y,
	input logic [COORD_WIDTH-1:0] r_fwd_x,
	input logic [COORD_WIDTH-1:0] r_fwd_y,
	input lbbp_pkg::status_t      r_status
);

	// only three status codes exist
	`LBBP_ASSERT_NOW(a_status_code, r_valid, r_status == lbbp_pkg::ST_OK || r_status == lbbp_pkg::ST_ZERO_DIR || r_status == lbbp_pkg::ST_SPLIT, "bad status code")

	// a failed item carries zero points
	`LBBP_ASSERT_NOW(a_fail_zero, r_valid && r_status != lbbp_pkg::ST_OK, r_back_x == '0 && r_back_y == '0 && r_fwd_x == '0 && r_fwd_y == '0, "failed item has nonzero points")

	// an offered query waits only when the whole pipe is backed up behind the result
	`LBBP_ASSERT_NOW(a_backpressure, q_valid && !q_ready, r_valid && !r_ready, "query stalled without result stall")

	// a stalled result holds its valid, back_x, fwd_y and status
	`LBBP_ASSERT_NEXT(a_hold, r_valid && !r_ready, r_valid && $stable(r_back_x) && $stable(r_fwd_y) && $stable(r_status), "stalled result changed")

endmodule

bind line_box_boundary_points_top lbbp_chk #(
	.COORD_WIDTH(COORD_WIDTH)
) u_lbbp_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.q_valid  (query.valid),
	.q_ready  (query.ready),
	.r_valid  (result.valid),
	.r_ready  (result.ready),
	.r_back_x (result.back_x),
	.r_back_y (result.back_y),
	.r_fwd_x  (result.fwd_x),
	.r_fwd_y  (result.fwd_y),
	.r_status (result.status)
);

/* test/lbbp_checker.sv */
// Checker for the line box boundary points block: predicts each query and compares results.
`timescale 1ns / 1ps
module lbbp_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  lbbp_pkg::cfg_idx_t cfg_idx,
	input  logic [31:0]   cfg_wdata,
	lbbp_query_if         query,
	lbbp_result_if        result,
	output int            errors,
	output int            pending
);

	typedef struct packed {
		logic signed [31:0] back_x;
		logic signed [31:0] back_y;
		logic signed [31:0] fwd_x;
		logic signed [31:0] fwd_y;
		lbbp_pkg::status_t  status;
	} bounds_t;

	localparam longint COORD_MAX = 64'sd2147483647;
	localparam longint COORD_MIN = -64'sd2147483648;

	logic signed [31:0] box_ax, box_ay, box_bx, box_by;
	bounds_t            bounds_q[$];

	function automatic longint clamp32(input longint v);
		if (v > COORD_MAX) return COORD_MAX;
		if (v < COORD_MIN) return COORD_MIN;
		return v;
	endfunction

	// slab parameter in Q16.16; negative when the exact ratio is below zero
	function automatic longint slab_param(input longint c, input longint p, input longint d,
		output bit neg);
		longint diff;
		diff = c - p;
		neg = (diff != 0) && ((diff < 0) != (d < 0));
		return clamp32((diff * 64'sd65536) / d);
	endfunction

	// point plus direction times t, product floored back to Q16.16
	function automatic logic [31:0] walk(input longint p, input longint d, input longint t);
		longint prod;
		prod = d * t;
		return 32'(clamp32(p + (prod >>> 16)));
	endfunction

	function automatic longint absval(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic bounds_t predict_bounds(input logic signed [31:0] px_i,
		input logic signed [31:0] py_i, input logic signed [31:0] dx_i,
		input logic signed [31:0] dy_i);
		bounds_t r;
		longint  px, py, dx, dy;
		longint  t[4];
		bit      neg[4];
		longint  best_n, best_p;
		int      cnt_n, cnt_p;
		px = px_i; py = py_i; dx = dx_i; dy = dy_i;
		r = '0;
		best_n = 0; best_p = 0; cnt_n = 0; cnt_p = 0;
		if (dx == 0 || dy == 0) begin
			r.status = lbbp_pkg::ST_ZERO_DIR;
			return r;
		end
		t[0] = slab_param(longint'(box_ax), px, dx, neg[0]);
		t[1] = slab_param(longint'(box_ay), py, dy, neg[1]);
		t[2] = slab_param(longint'(box_bx), px, dx, neg[2]);
		t[3] = slab_param(longint'(box_by), py, dy, neg[3]);
		// smallest magnitude in each group, earlier wins a tie
		for (int i = 0; i < 4; i++) begin
			if (neg[i]) begin
				if (cnt_n == 0 || absval(t[i]) < absval(best_n)) best_n = t[i];
				cnt_n++;
			end else begin
				if (cnt_p == 0 || absval(t[i]) < absval(best_p)) best_p = t[i];
				cnt_p++;
			end
		end
		if (cnt_n != 2) begin
			r.status = lbbp_pkg::ST_SPLIT;
			return r;
		end
		r.back_x = walk(px, dx, best_n);
		r.back_y = walk(py, dy, best_n);
		r.fwd_x  = walk(px, dx, best_p);
		r.fwd_y  = walk(py, dy, best_p);
		r.status = lbbp_pkg::ST_OK;
		return r;
	endfunction

	assign pending = bounds_q.size();

	// track registers, queue predictions, compare results
	always @(posedge clk or negedge arst_n) begin
		bounds_t want, got;
		if (!arst_n) begin
			box_ax = '0; box_ay = '0;
			box_bx = lbbp_pkg::CORNER_B_RST[31:0]; box_by = lbbp_pkg::CORNER_B_RST[31:0];
			errors = 0;
			bounds_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					lbbp_pkg::REG_A_X: box_ax = cfg_wdata;
					lbbp_pkg::REG_A_Y: box_ay = cfg_wdata;
					lbbp_pkg::REG_B_X: box_bx = cfg_wdata;
					lbbp_pkg::REG_B_Y: box_by = cfg_wdata;
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				got = '{result.back_x, result.back_y, result.fwd_x, result.fwd_y,
					result.status};
				if (bounds_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result item: %0d %0d %0d %0d st %0d",
							got.back_x, got.back_y, got.fwd_x, got.fwd_y, got.status);
				end else begin
					want = bounds_q.pop_front();
					if (want.back_x !== got.back_x || want.back_y !== got.back_y ||
						want.fwd_x !== got.fwd_x || want.fwd_y !== got.fwd_y ||
						want.status !== got.status) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp %0d %0d %0d %0d st %0d, got %0d %0d %0d %0d st %0d",
								want.back_x, want.back_y, want.fwd_x, want.fwd_y, want.status,
								got.back_x, got.back_y, got.fwd_x, got.fwd_y, got.status);
					end
				end
			end
			if (query.valid && query.ready)
				bounds_q.insert(bounds_q.size(), predict_bounds(query.point_x,
					query.point_y, query.dir_x, query.dir_y));
		end
	end
endmodule

/* test/tb_line_box_boundary_points_top.sv */
// Testbench top for the line box boundary points block: stimulus, config phases, verdict.
`timescale 1ns / 1ps
module tb_line_box_boundary_points_top;

	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_WAIT  = 60;
	localparam int RAND_PER_PHASE = 230;

	logic     clk;
	logic     arst_n;
	logic     cfg_we;
	lbbp_pkg::cfg_idx_t cfg_idx;
	logic [31:0] cfg_wdata;
	logic     q_acc;
	bit       no_idle;
	bit       hold_start;
	int       errors;
	int       pending;
	int       stall_cnt;

	lbbp_query_if  query_ch ();
	lbbp_result_if result_ch ();

	line_box_boundary_points_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.query     (query_ch),
		.result    (result_ch)
	);

	lbbp_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.query     (query_ch),
		.result    (result_ch),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// query accept as seen at the last rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) q_acc <= 1'b0;
		else q_acc <= query_ch.valid && query_ch.ready;
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((query_ch.valid && query_ch.ready) || (result_ch.valid && result_ch.ready))
				stall_cnt <= 0;
			else
				stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end else
			stall_cnt <= 0;
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_start && !hold_done) begin
				hold_done = 1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				result_ch.ready = 1'b0;
				hold_left--;
			end else if (no_idle)
				result_ch.ready = 1'b1;
			else
				result_ch.ready = ($urandom_range(99) >= 8);
		end
	end

	task automatic send_query(input logic [31:0] px, input logic [31:0] py,
		input logic [31:0] dx, input logic [31:0] dy);
		query_ch.valid   = 1'b1;
		query_ch.point_x = px;
		query_ch.point_y = py;
		query_ch.dir_x   = dx;
		query_ch.dir_y   = dy;
		do @(negedge clk); while (!q_acc);
		if (!no_idle && $urandom_range(99) < 8) begin
			query_ch.valid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
	endtask

	task automatic write_reg(input lbbp_pkg::cfg_idx_t idx, input logic [31:0] val);
		cfg_we    = 1'b1;
		cfg_idx   = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic drain();
		query_ch.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic set_box(input logic [31:0] ax, input logic [31:0] ay,
		input logic [31:0] bx, input logic [31:0] by);
		drain();
		write_reg(lbbp_pkg::REG_A_X, ax);
		write_reg(lbbp_pkg::REG_A_Y, ay);
		write_reg(lbbp_pkg::REG_B_X, bx);
		write_reg(lbbp_pkg::REG_B_Y, by);
	endtask

	function automatic logic [31:0] pick_between(input logic signed [31:0] a,
		input logic signed [31:0] b);
		longint lo, hi;
		longint unsigned span, r;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		span = longint'(hi - lo) + 1;
		r = {$urandom, $urandom};
		return 32'(lo + longint'(r % span));
	endfunction

	function automatic logic [31:0] pick_dir();
		int k;
		logic [31:0] m;
		k = $urandom_range(99);
		if (k < 4) return '0;
		if (k < 25) return $urandom;
		m = $urandom_range(0, 31);
		m = ($urandom & ((32'd1 << m) - 1)) | 32'd1;
		return ($urandom_range(1)) ? -m : m;
	endfunction

	task automatic random_queries(input int n, input logic [31:0] ax, input logic [31:0] ay,
		input logic [31:0] bx, input logic [31:0] by);
		logic [31:0] px, py;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 80) begin
				px = pick_between(ax, bx);
				py = pick_between(ay, by);
			end else begin
				px = $urandom;
				py = $urandom;
			end
			send_query(px, py, pick_dir(), pick_dir());
		end
	endtask

	// one phase: load the box, then random queries against it
	task automatic run_phase(input logic [31:0] ax, input logic [31:0] ay,
		input logic [31:0] bx, input logic [31:0] by, input int n);
		set_box(ax, ay, bx, by);
		random_queries(n, ax, ay, bx, by);
	endtask

	initial begin
		logic [31:0] ra, rb, rc, rd;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = lbbp_pkg::REG_A_X;
		cfg_wdata = '0;
		no_idle = 0;
		hold_start = 0;
		query_ch.valid = 1'b0;
		query_ch.point_x = '0;
		query_ch.point_y = '0;
		query_ch.dir_x = '0;
		query_ch.dir_y = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed cases on the reset box [0,1]x[0,1]
		send_query(32'h8000, 32'h8000, 32'h0, 32'h10000);          // zero x direction
		send_query(32'h8000, 32'h8000, 32'h10000, 32'h0);          // zero y direction
		send_query(32'h8000, 32'h8000, 32'h0, 32'h0);
		send_query(32'h8000, 32'h8000, 32'h10000, 32'h10000);      // tie on both sides
		send_query(32'h8000, 32'h4000, 32'hffff0000, 32'h10000);
		send_query(32'h8000, 32'h8000, 32'h1, 32'h1);              // tiny direction, saturates
		send_query(32'h8000, 32'h8000, 32'h7fffffff, 32'h80000000);
		send_query(32'h8000, 32'h8000, 32'h80000000, 32'h7fffffff);
		send_query(32'h0, 32'h8000, 32'h10000, 32'h10000);         // on the boundary: uneven
		send_query(32'h1, 32'h1, 32'h7fffffff, 32'h7fffffff);      // negative, truncates to 0
		send_query(32'h7fffffff, 32'h7fffffff, 32'h10000, 32'h10000);
		send_query(32'h80000000, 32'h80000000, 32'h10000, 32'hffff0000);
		send_query(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000);
		send_query(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
		send_query(32'h4000, 32'hc000, 32'h30000, 32'hfffd0000);

		// extremes of the box
		set_box(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
		send_query(32'h0, 32'h0, 32'h1, 32'h1);
		send_query(32'h0, 32'h0, 32'h80000000, 32'h7fffffff);
		send_query(32'h7ffffffe, 32'h80000001, 32'h10000, 32'hffff0000);
		send_query(32'h12345678, 32'hedcba987, 32'h3, 32'hfffffffd);
		random_queries(RAND_PER_PHASE, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);

		// reversed corners, long hold-off at the result side
		set_box(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
		hold_start = 1;
		random_queries(RAND_PER_PHASE, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);

		// stretch with no idling on either side
		no_idle = 1;
		run_phase(32'hfff00000, 32'hfff00000, 32'h00100000, 32'h00100000, RAND_PER_PHASE);
		no_idle = 0;

		run_phase(32'h0, 32'h0, 32'h0, 32'h0, 40);                  // degenerate box
		run_phase(32'h00010000, 32'hffff0000, 32'h00020000, 32'h00050000, RAND_PER_PHASE);
		for (int p = 0; p < 4; p++) begin
			ra = $urandom; rb = $urandom; rc = $urandom; rd = $urandom;
			run_phase(ra, rb, rc, rd, RAND_PER_PHASE);
		end

		// end of stimulus
		drain();
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
